@@ hw/rtl/mtrs_pkg.sv @@
// Types, constants and word functions of the MT19937 random source.
package mtrs_pkg;

   typedef logic [31:0] word_type;
   typedef logic [9:0]  addr_type;
   typedef logic [16:0] range_type;
   typedef logic [15:0] half_type;

   localparam int unsigned N_WORDS  = 624;
   localparam int unsigned M_OFFSET = 397;

   localparam addr_type ADDR_ZERO   = 10'd0;
   localparam addr_type ADDR_ONE    = 10'd1;
   localparam addr_type ADDR_M      = 10'd397;
   localparam addr_type ADDR_LAST   = 10'd623;
   localparam addr_type INDEX_FULL  = 10'd624;
   localparam logic [10:0] WRAP_AT  = 11'd624;
   localparam logic [10:0] STEP_TWO = 11'd2;
   localparam logic [10:0] STEP_FAR = 11'd398;

   localparam word_type TWIST_XOR     = 32'h9908_b0df;
   localparam word_type HIGH_BIT_MASK = 32'h8000_0000;
   localparam word_type LOW_BITS_MASK = 32'h7fff_ffff;
   localparam word_type TEMPER_B   = 32'h9d2c_5680;
   localparam word_type TEMPER_C   = 32'hefc6_0000;
   localparam word_type INIT_MULT  = 32'd1812433253;
   localparam word_type OLD_MULT   = 32'd69069;
   localparam word_type OLD_SEED   = 32'd4357;
   localparam range_type RANGE_MAX = 17'h1_0000;

   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_SEED = 1'b1;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      word_type wdata;
      addr_type raddr_a;
      addr_type raddr_b;
   } mem_cmd_type;

   typedef struct packed {
      logic      load;
      range_type range;
   } out_cmd_type;

   // Index into the state ring; the sum stays below twice the ring size.
   function automatic addr_type wrap_addr(input logic [10:0] s);
      if (s >= WRAP_AT) return addr_type'(s - WRAP_AT);
      return addr_type'(s);
   endfunction

   function automatic word_type twist_word(input word_type cur, input word_type nxt,
                                           input word_type far);
      word_type y;
      y = (cur & HIGH_BIT_MASK) | (nxt & LOW_BITS_MASK);
      return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
   endfunction

   // One initialization step; a single multiplier serves both seeding schemes.
   function automatic word_type seed_next(input word_type p, input addr_type i,
                                          input logic old);
      word_type mul;
      word_type opd;
      word_type add;
      mul = old ? OLD_MULT : INIT_MULT;
      opd = old ? p : (p ^ (p >> 30));
      add = old ? '0 : {22'b0, i};
      return word_type'(mul * opd) + add;
   endfunction

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ hw/rtl/mtrs_req_if.sv @@
// Request channel: valid/ready handshake with mode, seed and range.
interface mtrs_req_if;
   import mtrs_pkg::*;

   logic      valid;
   logic      ready;
   logic      mode;
   word_type  seed;
   range_type range;

   modport source (output valid, mode, seed, range, input ready);
   modport sink   (input valid, mode, seed, range, output ready);
endinterface

@@ hw/rtl/mtrs_rsp_if.sv @@
// Response channel: valid/ready handshake with the tempered word and scaled value.
interface mtrs_rsp_if;
   import mtrs_pkg::*;

   logic     valid;
   logic     ready;
   word_type random_word;
   half_type scaled_value;

   modport source (output valid, random_word, scaled_value, input ready);
   modport sink   (input valid, random_word, scaled_value, output ready);
endinterface

@@ hw/rtl/mtrs_state_ram.sv @@
// State word memory: one write port and two registered read ports.
module mtrs_state_ram (
   input  logic                clock,
   input  mtrs_pkg::mem_cmd_type cmd,
   output mtrs_pkg::word_type  rd_a,
   output mtrs_pkg::word_type  rd_b
);
   import mtrs_pkg::*;

   word_type mem [N_WORDS];
   word_type rd_a_ff;
   word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      rd_a_ff <= mem[cmd.raddr_a];
      rd_b_ff <= mem[cmd.raddr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;
endmodule

@@ hw/rtl/mtrs_seq.sv @@
// Sequencer: request intake, seed fill, pipelined twist pass and draw reads.
module mtrs_seq (
   input  logic                  clock,
   input  logic                  reset,
   mtrs_req_if.sink              req_ch,
   input  mtrs_pkg::word_type    rd_a,
   input  mtrs_pkg::word_type    rd_b,
   input  logic                  out_free,
   output mtrs_pkg::mem_cmd_type mem_cmd,
   output mtrs_pkg::out_cmd_type out_cmd
);
   import mtrs_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_FILL      = 3'd1;
   localparam logic [2:0] ST_PRIME     = 3'd2;
   localparam logic [2:0] ST_LOAD      = 3'd3;
   localparam logic [2:0] ST_TWIST     = 3'd4;
   localparam logic [2:0] ST_DRAW_WAIT = 3'd5;
   localparam logic [2:0] ST_DRAW_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       seeded_ff, seeded_in;
   addr_type   index_ff, index_in;
   addr_type   cnt_ff, cnt_in;
   word_type   prev_ff, prev_in;
   logic       old_ff, old_in;
   logic       pend_ff, pend_in;
   range_type  range_ff, range_in;

   addr_type   draw_pos;
   word_type   fill_word;

   assign draw_pos  = INDEX_FULL - index_ff;
   assign fill_word = seed_next(prev_ff, cnt_ff, old_ff);
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      index_in  = index_ff;
      cnt_in    = cnt_ff;
      prev_in   = prev_ff;
      old_in    = old_ff;
      pend_in   = pend_ff;
      range_in  = range_ff;
      mem_cmd   = '0;
      out_cmd.load  = 1'b0;
      out_cmd.range = range_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               range_in = req_ch.range;
               if (req_ch.mode == MODE_SEED) begin
                  mem_cmd.we    = 1'b1;
                  mem_cmd.waddr = ADDR_ZERO;
                  mem_cmd.wdata = req_ch.seed;
                  prev_in   = req_ch.seed;
                  cnt_in    = ADDR_ONE;
                  old_in    = 1'b0;
                  pend_in   = 1'b0;
                  seeded_in = 1'b1;
                  state_in  = ST_FILL;
               end else if (!seeded_ff) begin
                  // first draw without a seed: old scheme, then draw
                  mem_cmd.we    = 1'b1;
                  mem_cmd.waddr = ADDR_ZERO;
                  mem_cmd.wdata = OLD_SEED;
                  prev_in   = OLD_SEED;
                  cnt_in    = ADDR_ONE;
                  old_in    = 1'b1;
                  pend_in   = 1'b1;
                  seeded_in = 1'b1;
                  state_in  = ST_FILL;
               end else if (index_ff == ADDR_ZERO) begin
                  pend_in  = 1'b1;
                  state_in = ST_PRIME;
               end else if (out_free) begin
                  mem_cmd.raddr_a = draw_pos;
                  state_in = ST_DRAW_OUT;
               end else begin
                  state_in = ST_DRAW_WAIT;
               end
            end
         end
         ST_FILL: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = cnt_ff;
            mem_cmd.wdata = fill_word;
            prev_in = fill_word;
            cnt_in  = cnt_ff + ADDR_ONE;
            if (cnt_ff == ADDR_LAST) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            mem_cmd.raddr_a = ADDR_ZERO;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // word 0 arrives; issue reads for the first twist step
            prev_in = rd_a;
            mem_cmd.raddr_a = ADDR_ONE;
            mem_cmd.raddr_b = ADDR_M;
            cnt_in   = ADDR_ZERO;
            state_in = ST_TWIST;
         end
         ST_TWIST: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = cnt_ff;
            mem_cmd.wdata = twist_word(prev_ff, rd_a, rd_b);
            mem_cmd.raddr_a = wrap_addr({1'b0, cnt_ff} + STEP_TWO);
            mem_cmd.raddr_b = wrap_addr({1'b0, cnt_ff} + STEP_FAR);
            prev_in = rd_a;
            cnt_in  = cnt_ff + ADDR_ONE;
            if (cnt_ff == ADDR_LAST) begin
               index_in = INDEX_FULL;
               pend_in  = 1'b0;
               state_in = pend_ff ? ST_DRAW_WAIT : ST_IDLE;
            end
         end
         ST_DRAW_WAIT: begin
            // hold the read until the response register frees up
            if (out_free) begin
               mem_cmd.raddr_a = draw_pos;
               state_in = ST_DRAW_OUT;
            end
         end
         ST_DRAW_OUT: begin
            out_cmd.load = 1'b1;
            index_in = index_ff - ADDR_ONE;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seeded_ff <= 1'b0;
         index_ff  <= ADDR_ZERO;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
         index_ff  <= index_in;
         pend_ff   <= pend_in;
      end
      cnt_ff   <= cnt_in;
      prev_ff  <= prev_in;
      old_ff   <= old_in;
      range_ff <= range_in;
   end

   a_twist_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TWIST) |->
         (mem_cmd.waddr != mem_cmd.raddr_a) && (mem_cmd.waddr != mem_cmd.raddr_b))
      else $error("twist write collides with a read in flight");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_OUT) |-> $past(out_free))
      else $error("draw read issued while response register was held");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= INDEX_FULL)
      else $error("read index beyond state size");

   a_draw_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_OUT) |-> (seeded_ff && (index_ff != ADDR_ZERO)))
      else $error("draw completes from an exhausted or unseeded state");
endmodule

@@ hw/rtl/mtrs_out_stage.sv @@
// Output stage: temper the drawn word, scale it and hold the response.
module mtrs_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  mtrs_pkg::word_type    rd_word,
   input  mtrs_pkg::out_cmd_type out_cmd,
   output logic                  out_free,
   mtrs_rsp_if.source            rsp_ch
);
   import mtrs_pkg::*;

   logic      valid_ff, valid_in;
   word_type  word_ff, word_in;
   half_type  scaled_ff, scaled_in;
   range_type range_sat;
   logic [32:0] product;

   assign range_sat = out_cmd.range[16] ? RANGE_MAX : out_cmd.range;
   assign word_in   = temper(rd_word);
   assign product   = {17'b0, word_in[15:0]} * {16'b0, range_sat};
   assign scaled_in = product[31:16];

   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_cmd.load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (out_cmd.load) begin
         word_ff   <= word_in;
         scaled_ff <= scaled_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.random_word  = word_ff;
   assign rsp_ch.scaled_value = scaled_ff;
endmodule

@@ hw/rtl/mersenne_twister_random_source_top.sv @@
// MT19937 random source: 624-word state memory, sequencer and output register.
//
// Requests arrive on req_ch (valid/ready). Mode 1 seeds the generator and
// returns nothing; mode 0 draws one word and returns the tempered word and
// (low 16 bits * range, capped at 0x10000) >> 16 on rsp_ch (valid/ready).
// A draw from a ready state reads its word from the state memory and loads
// it into the response register. rsp_ch.valid rises in the same cycle that
// req_ch.ready returns, so a new request is taken only once a draw is done.
// A draw that finds all 624 words used first runs a twist pass over the
// memory, one word written per cycle while two words are read ahead.
// A seed request occupies the block for a fill pass (one multiply per
// word) followed by the twist pass. A draw with no prior seed seeds with
// 4357 by the old scheme first, at the same cost.
// Reset clears the read index and the seeded flag; the state memory is not
// cleared and needs no clearing pass. req_ch.ready is high only while idle.
// While rsp_ch is stalled the held response stays put; a following draw is
// accepted and waits before its memory read until the register frees up.
module mersenne_twister_random_source_top (
   input  logic       clock,
   input  logic       reset,
   mtrs_req_if.sink   req_ch,
   mtrs_rsp_if.source rsp_ch
);
   import mtrs_pkg::*;

   mem_cmd_type mem_cmd;
   out_cmd_type out_cmd;
   word_type    rd_a;
   word_type    rd_b;
   logic        out_free;

   mtrs_state_ram u_ram (
      .clock (clock),
      .cmd   (mem_cmd),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   mtrs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .out_free (out_free),
      .mem_cmd  (mem_cmd),
      .out_cmd  (out_cmd)
   );

   mtrs_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .rd_word  (rd_a),
      .out_cmd  (out_cmd),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );
endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the MT19937 random source: seeded and unseeded draws.
module testbench;
   import mtrs_pkg::*;

   typedef struct {
      logic      mode;
      word_type  seed;
      range_type range;
   } mt_request_type;

   typedef struct {
      word_type word;
      half_type scaled;
   } draw_result_type;

   localparam int IDLE_LIMIT  = 10000;
   localparam int DRAIN_WAIT  = 1400;
   localparam int QUIET_TAIL  = 150;
   localparam int RANDOM_ITEMS = 1000;

   logic clock;
   logic reset;

   mtrs_req_if req_ch ();
   mtrs_rsp_if rsp_ch ();

   mersenne_twister_random_source_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mt_request_type  pending_requests[$];
   draw_result_type expected_draws[$];

   // Predicted generator state
   word_type model_words [N_WORDS];
   int       words_left;
   bit       is_seeded;

   int  mismatches;
   int  seeds_sent;
   int  draws_sent;
   int  twists_seen;
   int  draws_checked;
   int  gap_left;
   int  stall_left;
   int  idle_cycles;
   logic quiet;

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h (response %0d)",
               what, got, want, draws_checked);
      mismatches++;
   endtask

   function automatic word_type temper_word(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Regenerate all words in place, in ascending order as the standard does.
   function automatic void twist_state();
      word_type y;
      for (int k = 0; k < N_WORDS; k++) begin
         y = (model_words[k] & HIGH_BIT_MASK)
             | (model_words[(k + 1) % N_WORDS] & LOW_BITS_MASK);
         model_words[k] = model_words[(k + M_OFFSET) % N_WORDS] ^ (y >> 1)
                          ^ (y[0] ? TWIST_XOR : word_type'(0));
      end
      words_left = N_WORDS;
      twists_seen++;
   endfunction

   function automatic void load_seed(input word_type s, input bit old_scheme);
      word_type p;
      model_words[0] = s;
      for (int i = 1; i < N_WORDS; i++) begin
         p = model_words[i - 1];
         if (old_scheme)
            model_words[i] = OLD_MULT * p;
         else
            model_words[i] = INIT_MULT * (p ^ (p >> 30)) + word_type'(i);
      end
      is_seeded = 1'b1;
      twist_state();
   endfunction

   function automatic draw_result_type draw_next(input range_type r);
      draw_result_type res;
      word_type     w;
      range_type    span;
      logic [32:0]  prod;
      if (!is_seeded)
         load_seed(OLD_SEED, 1'b1);
      else if (words_left == 0)
         twist_state();
      w = temper_word(model_words[N_WORDS - words_left]);
      words_left--;
      span = (r > RANGE_MAX) ? RANGE_MAX : r;
      prod = w[15:0] * span;
      res.word = w;
      res.scaled = prod[31:16];
      return res;
   endfunction

   function automatic void predict_request(input logic mode, input word_type s,
                                           input range_type r);
      if (mode == MODE_SEED) begin
         load_seed(s, 1'b0);
         seeds_sent++;
      end else begin
         expected_draws.push_back(draw_next(r));
         draws_sent++;
      end
   endfunction

   function automatic void add_request(input logic mode, input word_type s,
                                       input range_type r);
      mt_request_type item;
      item.mode = mode;
      item.seed = s;
      item.range = r;
      pending_requests.push_back(item);
   endfunction

   function automatic range_type pick_range();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return RANGE_MAX;
         2: return range_type'($urandom_range(32'h1_0001, 32'h1_ffff));
         default: return range_type'($urandom_range(1, 32'hffff));
      endcase
   endfunction

   function automatic word_type pick_seed();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Driver: present requests, predict on acceptance, insert random gaps
   always @(posedge clock) begin
      mt_request_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         quiet <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_request(req_ch.mode, req_ch.seed, req_ch.range);
         quiet <= (pending_requests.size() < QUIET_TAIL);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 16);
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               item = pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.mode  <= item.mode;
               req_ch.seed  <= item.seed;
               req_ch.range <= item.range;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest predicted draw, stall at random
   always @(posedge clock) begin
      draw_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_draws.size() == 0) begin
               report_mismatch("response with no draw pending", rsp_ch.random_word, '0);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_ch.random_word !== want.word)
                  report_mismatch("random_word", rsp_ch.random_word, want.word);
               if (rsp_ch.scaled_value !== want.scaled)
                  report_mismatch("scaled_value", word_type'(rsp_ch.scaled_value),
                                  word_type'(want.scaled));
            end
            draws_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: give up after a long stretch with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d requests still queued",
                  IDLE_LIMIT, pending_requests.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int total;
      int seg_len;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode  = MODE_DRAW;
      req_ch.seed  = '0;
      req_ch.range = '0;
      rsp_ch.ready = 1'b0;
      quiet = 1'b0;
      mismatches = 0;
      seeds_sent = 0;
      draws_sent = 0;
      twists_seen = 0;
      draws_checked = 0;
      gap_left = 0;
      stall_left = 0;
      idle_cycles = 0;
      words_left = 0;
      is_seeded = 1'b0;
      foreach (model_words[k]) model_words[k] = '0;

      // Directed: unseeded first draw, range extremes, seed extremes
      add_request(MODE_DRAW, '1, RANGE_MAX);
      add_request(MODE_DRAW, '0, '0);
      add_request(MODE_DRAW, 32'h1234_5678, 17'd1);
      add_request(MODE_DRAW, '0, 17'h0_ffff);
      add_request(MODE_DRAW, '0, 17'h1_ffff);
      add_request(MODE_DRAW, '0, 17'h1_0001);
      add_request(MODE_SEED, '0, 17'h1_ffff);
      add_request(MODE_DRAW, '0, RANGE_MAX);
      add_request(MODE_DRAW, '1, '0);
      add_request(MODE_SEED, '1, '0);
      add_request(MODE_DRAW, 32'ha5a5_a5a5, 17'd12345);
      add_request(MODE_DRAW, '0, 17'd2);
      add_request(MODE_SEED, 32'd5489, 17'h0_aaaa);
      add_request(MODE_DRAW, '0, RANGE_MAX);
      add_request(MODE_DRAW, '0, 17'd100);
      add_request(MODE_DRAW, 32'h5a5a_5a5a, 17'h1_5555);
      add_request(MODE_SEED, 32'h8000_0001, RANGE_MAX);
      add_request(MODE_SEED, 32'h7fff_fffe, 17'd1);
      add_request(MODE_DRAW, '0, 17'h0_8000);

      // Random: runs of draws between reseeds; the first run goes past the end
      // of the state so the refill path is exercised
      total = 0;
      seg_len = $urandom_range(640, 700);
      while (total < RANDOM_ITEMS) begin
         if (seg_len > RANDOM_ITEMS - total)
            seg_len = RANDOM_ITEMS - total;
         repeat (seg_len) add_request(MODE_DRAW, $urandom, pick_range());
         total += seg_len;
         add_request(MODE_SEED, pick_seed(), range_type'($urandom_range(0, 32'h1_ffff)));
         total++;
         if ($urandom_range(0, 4) == 0)
            seg_len = $urandom_range(600, 700);
         else
            seg_len = $urandom_range(0, 40);
      end
      add_request(MODE_DRAW, $urandom, pick_range());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_ch.valid || expected_draws.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d seed and %0d draw requests; %0d responses checked",
               seeds_sent, draws_sent, draws_checked);
      $display("Predicted %0d full-state twists; %0d mismatches", twists_seen, mismatches);
      if (mismatches == 0 && expected_draws.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
